### sv/integer_to_radix_digits_core_assert.svh
// Assertion macros shared by the radix conversion core modules.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITRD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/itrd_pkg.sv
// Shared types, constants and the digit character table for the radix core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itrd_pkg;

    localparam int DEF_VALUE_WIDTH = 31;
    localparam int RADIX_W         = 5;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 7;
    // Quotient bits resolved per divider cycle
    localparam int STEP_BITS       = 8;
    // Command queue depth, a power of two
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

    // Classified command handed from the front to the back
    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic               is_zero;
    } t_cmd_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_back_state;

    // Map a digit value to its uppercase ASCII character
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        case (d)
            4'h0:    c = 7'h30;
            4'h1:    c = 7'h31;
            4'h2:    c = 7'h32;
            4'h3:    c = 7'h33;
            4'h4:    c = 7'h34;
            4'h5:    c = 7'h35;
            4'h6:    c = 7'h36;
            4'h7:    c = 7'h37;
            4'h8:    c = 7'h38;
            4'h9:    c = 7'h39;
            4'hA:    c = 7'h41;
            4'hB:    c = 7'h42;
            4'hC:    c = 7'h43;
            4'hD:    c = 7'h44;
            4'hE:    c = 7'h45;
            default: c = 7'h46;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/itrd_front.sv
// Front end: takes items, clamps the radix, flags zero and queues commands.
// Depends on itrd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_radix_digits_core_assert.svh"

module itrd_front
    import itrd_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    output logic                        o_busy,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic [RADIX_W-1:0]     i_radix,
    output logic                        o_cmd_valid,
    input  wire logic                   i_cmd_ready,
    output logic [VALUE_WIDTH-1:0]      o_cmd_value,
    output t_cmd_ctl                    o_cmd_ctl
);

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    logic [VALUE_WIDTH-1:0] r_q_value [QUEUE_DEPTH];
    t_cmd_ctl               r_q_ctl   [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]       r_count,  n_count;
    t_cmd_ctl               in_ctl;
    logic                   push;
    logic                   pop;

    // Classify the incoming beat: clamp radix to 2..16, flag a zero value
    always_comb begin
        if (i_radix < RADIX_MIN) begin
            in_ctl.radix = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            in_ctl.radix = RADIX_MAX;
        end else begin
            in_ctl.radix = i_radix;
        end
        in_ctl.is_zero = (i_value == '0);
    end

    // Queue handshake
    assign o_busy      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign push        = i_start && !o_busy;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd_value = r_q_value[r_rd_ptr];
    assign o_cmd_ctl   = r_q_ctl[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Hold the queued payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_value[r_wr_ptr] <= i_value;
            r_q_ctl[r_wr_ptr]   <= in_ctl;
        end
    end

    `ITRD_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `ITRD_ASSERT_NEXT(a_push_grows, push && !pop, r_count == $past(r_count) + CNT_W'(1), "push lost")
    `ITRD_ASSERT_NEXT(a_pop_shrinks, pop && !push, r_count == $past(r_count) - CNT_W'(1), "pop lost")

endmodule

`default_nettype wire

### sv/itrd_back.sv
// Back end: repeated division by the radix, digit stack, reversed emission.
// Depends on itrd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_radix_digits_core_assert.svh"

module itrd_back
    import itrd_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cmd_valid,
    output logic                        o_cmd_ready,
    input  wire logic [VALUE_WIDTH-1:0] i_cmd_value,
    input  wire t_cmd_ctl               i_cmd_ctl,
    output logic                        o_valid,
    output logic [CHAR_W-1:0]           o_digit_char,
    output logic                        o_last_digit
);

    localparam int STEPS  = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W  = STEPS * STEP_BITS;
    localparam int AW     = $clog2(VALUE_WIDTH);
    localparam int SP_W   = AW + 1;
    localparam int SCNT_W = $clog2(STEPS + 1);

    t_back_state          r_state, n_state;
    logic [PAD_W-1:0]     r_dvd;
    logic [DIGIT_W-1:0]   r_rem;
    logic [RADIX_W-1:0]   r_radix;
    logic [SCNT_W-1:0]    r_step;
    logic [SP_W-1:0]      r_sp;
    logic [DIGIT_W-1:0]   r_rd_data;
    logic                 r_rd_vld;
    logic                 r_rd_last;
    logic [DIGIT_W-1:0]   mem [VALUE_WIDTH];

    logic [PAD_W-1:0]     div_dvd;
    logic [DIGIT_W-1:0]   div_rem;
    logic                 step_last;
    logic                 quo_zero;
    logic                 sp_one;
    logic [SP_W-1:0]      sp_m1;
    logic                 load_div;
    logic                 load_zero;
    logic                 div_done;
    logic                 rd_en;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [DIGIT_W-1:0]   mem_wd;

    // Divider slice: resolve STEP_BITS quotient bits by restoring division
    always_comb begin
        logic [DIGIT_W:0]   rem_x;
        logic [DIGIT_W-1:0] rem;
        logic [PAD_W-1:0]   dvd;
        rem = r_rem;
        dvd = r_dvd;
        for (int i = 0; i < STEP_BITS; i++) begin
            rem_x = {rem, dvd[PAD_W-1]};
            dvd   = {dvd[PAD_W-2:0], 1'b0};
            if (rem_x >= r_radix) begin
                rem_x  = rem_x - r_radix;
                dvd[0] = 1'b1;
            end
            rem = rem_x[DIGIT_W-1:0];
        end
        div_dvd = dvd;
        div_rem = rem;
    end

    assign step_last = (r_step == SCNT_W'(STEPS - 1));
    assign quo_zero  = (div_dvd == '0);
    assign sp_one    = (r_sp == SP_W'(1));
    assign sp_m1     = r_sp - SP_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = i_cmd_ctl.is_zero ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_last && quo_zero) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sp_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_cmd_ready = 1'b0;
        load_div    = 1'b0;
        load_zero   = 1'b0;
        div_done    = 1'b0;
        rd_en       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                load_div    = i_cmd_valid && !i_cmd_ctl.is_zero;
                load_zero   = i_cmd_valid && i_cmd_ctl.is_zero;
            end
            ST_DIV: begin
                div_done = step_last;
            end
            ST_EMIT: begin
                rd_en = 1'b1;
            end
            default: o_cmd_ready = 1'b0;
        endcase
        mem_we = load_zero || div_done;
        mem_wa = load_zero ? '0 : r_sp[AW-1:0];
        mem_wd = load_zero ? '0 : div_rem;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_sp      <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= rd_en;
            r_rd_last <= rd_en && sp_one;
            if (load_div) begin
                r_step <= '0;
                r_sp   <= '0;
            end else if (load_zero) begin
                r_sp   <= SP_W'(1);
            end else if (r_state == ST_DIV) begin
                r_step <= step_last ? '0 : r_step + SCNT_W'(1);
                if (div_done) begin
                    r_sp <= r_sp + SP_W'(1);
                end
            end else if (rd_en) begin
                r_sp <= sp_m1;
            end
        end
    end

    // Dividend, partial remainder and radix
    always_ff @(posedge i_clk) begin
        if (load_div) begin
            r_dvd   <= PAD_W'(i_cmd_value);
            r_rem   <= '0;
            r_radix <= i_cmd_ctl.radix;
        end else if (r_state == ST_DIV) begin
            r_dvd <= div_dvd;
            r_rem <= step_last ? '0 : div_rem;
        end
    end

    // Digit stack: push least significant first, pop most significant first
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= mem[sp_m1[AW-1:0]];
        end
    end

    assign o_valid      = r_rd_vld;
    assign o_last_digit = r_rd_last;
    assign o_digit_char = digit_to_char(r_rd_data);

    `ITRD_ASSERT_NEXT(a_digits_contiguous, r_rd_vld && !r_rd_last, r_rd_vld, "digit gap")
    `ITRD_ASSERT_SAME(a_stack_room, r_state == ST_DIV, r_sp < SP_W'(VALUE_WIDTH), "stack overflow")
    `ITRD_ASSERT_NEXT(a_take_starts, i_cmd_valid && o_cmd_ready, r_state != ST_IDLE, "command dropped")

endmodule

`default_nettype wire

### sv/integer_to_radix_digits_core.sv
// A nonzero item is divided repeatedly by the radix, 8 quotient bits per cycle, and its digits
// go out one per cycle; a zero item skips the divider and emits a single '0'. The back end takes
// a new command only after reading the last digit of the previous one from its digit stack.
// busy rises only when the two-entry command queue is full; results cannot be stalled.
// Reset (synchronous, active low) empties the queue and returns the divider to idle.
// Top level: integer to ASCII digits in radix 2..16, built from itrd_front and itrd_back.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_radix_digits_core
    import itrd_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic [RADIX_W-1:0]     i_radix,
    output logic                        o_valid,
    output logic [CHAR_W-1:0]           o_digit_char,
    output logic                        o_last_digit
);

    logic                   cmd_valid;
    logic                   cmd_ready;
    logic [VALUE_WIDTH-1:0] cmd_value;
    t_cmd_ctl               cmd_ctl;

    // Accept and classify
    itrd_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_value    (i_value),
        .i_radix    (i_radix),
        .o_cmd_valid(cmd_valid),
        .i_cmd_ready(cmd_ready),
        .o_cmd_value(cmd_value),
        .o_cmd_ctl  (cmd_ctl)
    );

    // Convert and emit
    itrd_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd_value (cmd_value),
        .i_cmd_ctl   (cmd_ctl),
        .o_valid     (o_valid),
        .o_digit_char(o_digit_char),
        .o_last_digit(o_last_digit)
    );

endmodule

`default_nettype wire
